[design/long_press_action_selector_unit_macros.svh]
// Assertion macros for the long-press action selector
`ifndef LONG_PRESS_ACTION_SELECTOR_UNIT_MACROS_SVH
`define LONG_PRESS_ACTION_SELECTOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define LPAS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lpas assertion failed");
`define LPAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lpas assertion failed");
`else
`define LPAS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LPAS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[design/lpas_pkg.sv]
// Shared types and constants for the long-press action selector
package lpas_pkg;
	localparam int COUNT_W = 4;
	localparam int SETTING_WIDTH_DEF = 4;
	localparam int CFG_IDX_W = 2;
	localparam int HOLD_W = 13;
	localparam int TOGGLE_W = 12;
	localparam int FLASH_W = 8;
	localparam int LEVEL_W = 3;
	localparam int ACTION_W = 3;

	localparam int LVL1_MS = 5000;
	localparam int LVL2_MS = 3000;
	localparam int LVL3_MS = 1000;
	localparam int LVL4_MS = 25;
	localparam int PHASE_MS = 60;
	localparam int PERIOD_MS = 1000;

	typedef enum logic [LEVEL_W-1:0] {
		LVL_NONE    = 3'd0,
		LVL_SAVE    = 3'd1,
		LVL_POWER   = 3'd2,
		LVL_BAND    = 3'd3,
		LVL_CHANNEL = 3'd4
	} level_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_NONE    = 3'd0,
		ACT_CHANNEL = 3'd1,
		ACT_BAND    = 3'd2,
		ACT_POWER   = 3'd3,
		ACT_SAVE    = 3'd4
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BAND_COUNT    = 2'd0,
		REG_CHANNEL_COUNT = 2'd1,
		REG_POWER_COUNT   = 2'd2,
		REG_DEVICE_READY  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [COUNT_W-1:0] band_count;
		logic [COUNT_W-1:0] channel_count;
		logic [COUNT_W-1:0] power_count;
		logic               device_ready;
	} cfg_t;

	// release request from the hold timer to the settings unit
	typedef struct packed {
		logic   release_req;
		level_t level;
	} release_t;
endpackage

[design/lpas_hold.sv]
// Press timer, hold level decode and LED blink sequencer
module lpas_hold (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              down,
	output logic              led_next,
	output lpas_pkg::release_t rel
);
	import lpas_pkg::*;

	logic                pressing_q, pressing_n;
	logic [HOLD_W-1:0]   hold_q, hold_n;
	level_t              level_q, level_n;
	logic [TOGGLE_W-1:0] toggle_q, toggle_n;
	logic                led_q, led_n;
	logic [FLASH_W-1:0]  flash_q, flash_n;

	function automatic logic [TOGGLE_W-1:0] pause_ms(level_t lvl);
		logic [TOGGLE_W-1:0] p;
		case (lvl)
			LVL_SAVE:    p = TOGGLE_W'(PERIOD_MS - 2 * PHASE_MS * 1);
			LVL_POWER:   p = TOGGLE_W'(PERIOD_MS - 2 * PHASE_MS * 2);
			LVL_BAND:    p = TOGGLE_W'(PERIOD_MS - 2 * PHASE_MS * 3);
			LVL_CHANNEL: p = TOGGLE_W'(PERIOD_MS - 2 * PHASE_MS * 4);
			default:     p = '0;
		endcase
		return p;
	endfunction

	always_comb begin
		pressing_n = pressing_q;
		hold_n = hold_q;
		level_n = level_q;
		toggle_n = toggle_q;
		led_n = led_q;
		flash_n = flash_q;
		rel = '{release_req: 1'b0, level: level_q};
		if (down) begin
			if (!pressing_q) begin
				pressing_n = 1'b1;
				hold_n = '0;
				level_n = LVL_NONE;
				toggle_n = TOGGLE_W'(1);
				led_n = 1'b0;
				flash_n = '0;
			end else begin
				if (hold_q != {HOLD_W{1'b1}})
					hold_n = hold_q + HOLD_W'(1);
				if (toggle_q != '0)
					toggle_n = toggle_q - TOGGLE_W'(1);
			end
			if (hold_n > HOLD_W'(LVL1_MS))
				level_n = LVL_SAVE;
			else if (hold_n > HOLD_W'(LVL2_MS))
				level_n = LVL_POWER;
			else if (hold_n > HOLD_W'(LVL3_MS))
				level_n = LVL_BAND;
			else if (hold_n > HOLD_W'(LVL4_MS))
				level_n = LVL_CHANNEL;
			if (level_n != LVL_NONE && toggle_n == '0) begin
				led_n = !led_n;
				toggle_n = TOGGLE_W'(PHASE_MS + 1);
				if (!led_n)
					flash_n = flash_n + FLASH_W'(1);
				// last off phase of the group: pad the rest of the second
				if (flash_n == FLASH_W'(level_n)) begin
					toggle_n = TOGGLE_W'(PHASE_MS + 1) + pause_ms(level_n);
					flash_n = '0;
				end
			end
		end else if (pressing_q) begin
			pressing_n = 1'b0;
			rel.release_req = 1'b1;
			if (level_q != LVL_NONE)
				led_n = 1'b0;
			level_n = LVL_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressing_q <= 1'b0;
			hold_q <= '0;
			level_q <= LVL_NONE;
			toggle_q <= '0;
			led_q <= 1'b0;
			flash_q <= '0;
		end else if (adv) begin
			pressing_q <= pressing_n;
			hold_q <= hold_n;
			level_q <= level_n;
			toggle_q <= toggle_n;
			led_q <= led_n;
			flash_q <= flash_n;
		end
	end

	assign led_next = led_n;
endmodule

[design/lpas_settings.sv]
// Band, channel and power setting registers and release actions
module lpas_settings #(
	parameter int SETTING_WIDTH = lpas_pkg::SETTING_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  lpas_pkg::release_t       rel,
	input  lpas_pkg::cfg_t           cfg,
	output lpas_pkg::action_t        action_next,
	output logic [SETTING_WIDTH-1:0] band_next,
	output logic [SETTING_WIDTH-1:0] channel_next,
	output logic [SETTING_WIDTH-1:0] power_next
);
	import lpas_pkg::*;

	localparam int CW = (SETTING_WIDTH > COUNT_W ? SETTING_WIDTH : COUNT_W) + 1;

	logic [SETTING_WIDTH-1:0] band_q, channel_q, power_q;

	function automatic logic [SETTING_WIDTH-1:0] wrap_up(logic [SETTING_WIDTH-1:0] v,
		logic [COUNT_W-1:0] cnt);
		logic [CW-1:0] n;
		n = CW'(v) + CW'(1);
		return (n > CW'(cnt)) ? SETTING_WIDTH'(1) : n[SETTING_WIDTH-1:0];
	endfunction

	function automatic logic [SETTING_WIDTH-1:0] normalize(logic [SETTING_WIDTH-1:0] v,
		logic [COUNT_W-1:0] cnt);
		logic [SETTING_WIDTH-1:0] r;
		if (CW'(v) > CW'(cnt))
			r = SETTING_WIDTH'(1);
		else if (v == '0)
			r = SETTING_WIDTH'(cnt);
		else
			r = v;
		return r;
	endfunction

	logic [CW-1:0] power_inc;
	assign power_inc = CW'(power_q) + CW'(1);

	always_comb begin
		action_next = ACT_NONE;
		band_next = band_q;
		channel_next = channel_q;
		power_next = power_q;
		if (rel.release_req) begin
			case (rel.level)
				LVL_CHANNEL: begin
					if (cfg.device_ready) begin
						channel_next = wrap_up(channel_q, cfg.channel_count);
						band_next = normalize(band_q, cfg.band_count);
						action_next = ACT_CHANNEL;
					end
				end
				LVL_BAND: begin
					if (cfg.device_ready) begin
						band_next = wrap_up(band_q, cfg.band_count);
						channel_next = normalize(channel_q, cfg.channel_count);
						action_next = ACT_BAND;
					end
				end
				LVL_POWER: begin
					if (cfg.device_ready) begin
						power_next = (power_inc >= CW'(cfg.power_count)) ? '0 :
							power_inc[SETTING_WIDTH-1:0];
						action_next = ACT_POWER;
					end
				end
				LVL_SAVE: action_next = ACT_SAVE;
				default: action_next = ACT_NONE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_q <= SETTING_WIDTH'(1);
			channel_q <= SETTING_WIDTH'(1);
			power_q <= '0;
		end else if (adv) begin
			band_q <= band_next;
			channel_q <= channel_next;
			power_q <= power_next;
		end
	end
endmodule

[design/long_press_action_selector_unit.sv]
// Long-press action selector top level: tick input, config registers, result register
// Takes one button sample per millisecond tick and returns one result per tick
// (LED state, action code, current band/channel/power). An item is taken every
// clock cycle unless the input is stalled; results pass through one input register,
// one pass of timer/level/setting logic, then the result register. A stalled
// result holds the input register, which stalls the input in turn.
// Configuration writes are always ready and take effect on the next cycle.
module long_press_action_selector_unit #(
	parameter int SETTING_WIDTH = lpas_pkg::SETTING_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             button_down,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             led_lit,
	output logic [lpas_pkg::ACTION_W-1:0]    action_done,
	output logic [SETTING_WIDTH-1:0]         band_now,
	output logic [SETTING_WIDTH-1:0]         channel_now,
	output logic [SETTING_WIDTH-1:0]         power_now,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lpas_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lpas_pkg::COUNT_W-1:0]     cfg_data
);
	import lpas_pkg::*;
	`include "long_press_action_selector_unit_macros.svh"

	cfg_t cfg_q;
	logic valid_s1, down_s1;
	logic adv;
	logic led_nx;
	release_t rel;
	action_t act_nx;
	logic [SETTING_WIDTH-1:0] band_nx, channel_nx, power_nx;
	logic out_valid_q, led_q;
	logic [ACTION_W-1:0] action_q;
	logic [SETTING_WIDTH-1:0] band_q, channel_q, power_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.band_count <= COUNT_W'(5);
			cfg_q.channel_count <= COUNT_W'(8);
			cfg_q.power_count <= COUNT_W'(4);
			cfg_q.device_ready <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_BAND_COUNT:    cfg_q.band_count <= cfg_data;
				REG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_data;
				REG_POWER_COUNT:   cfg_q.power_count <= cfg_data;
				REG_DEVICE_READY:  cfg_q.device_ready <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// stage 1 item moves on when the result register is free or being taken
	assign adv = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_valid && !in_stall)
			valid_s1 <= 1'b1;
		else if (adv)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			down_s1 <= button_down;
	end

	lpas_hold u_hold (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.down     (down_s1),
		.led_next (led_nx),
		.rel      (rel)
	);

	lpas_settings #(
		.SETTING_WIDTH (SETTING_WIDTH)
	) u_settings (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.rel          (rel),
		.cfg          (cfg_q),
		.action_next  (act_nx),
		.band_next    (band_nx),
		.channel_next (channel_nx),
		.power_next   (power_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			led_q <= led_nx;
			action_q <= act_nx;
			band_q <= band_nx;
			channel_q <= channel_nx;
			power_q <= power_nx;
		end
	end

	assign out_valid = out_valid_q;
	assign led_lit = led_q;
	assign action_done = action_q;
	assign band_now = band_q;
	assign channel_now = channel_q;
	assign power_now = power_q;

	`LPAS_ASSERT_IMPL(a_action_led_off, clk, arst_n, out_valid_q && action_q != ACT_NONE, !led_q)
	`LPAS_ASSERT_IMPL(a_stall_has_item, clk, arst_n, in_stall, valid_s1 && out_valid_q)
	`LPAS_ASSERT_NEXT(a_adv_fills_out, clk, arst_n, adv, out_valid_q)
endmodule

[tb/long_press_action_selector_unit_tb.sv]
// Self-checking testbench for the long-press action selector: directed hold table, random presses
module long_press_action_selector_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lpas_pkg::*;

	localparam int SW = SETTING_WIDTH_DEF;
	localparam int HOLD_SAT = 2**HOLD_W - 1;
	localparam int PHASES = 6;
	localparam int PRESSES_PER_PHASE = 32;
	localparam int TICK_CAP = 170000;
	localparam int HOLD_OFF_CYCLES = 300;

	typedef struct packed {
		logic          lamp;
		action_t       act;
		logic [SW-1:0] band;
		logic [SW-1:0] chan;
		logic [SW-1:0] pwr;
	} tick_result_t;

	typedef enum bit {ROW_TICKS, ROW_WRITE} row_kind_t;

	// one row: a register write, or a run of identical ticks with an optional
	// hand-typed expectation for the last tick of the run
	typedef struct {
		row_kind_t     kind;
		cfg_reg_t      idx;
		logic [3:0]    val;
		logic          down;
		int            reps;
		bit            pinned;
		action_t       act;
		logic [SW-1:0] band;
		logic [SW-1:0] chan;
		logic [SW-1:0] pwr;
	} hold_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic button_down = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic led_lit;
	logic [ACTION_W-1:0] action_done;
	logic [SW-1:0] band_now;
	logic [SW-1:0] channel_now;
	logic [SW-1:0] power_now;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_reg_t cfg_index = REG_BAND_COUNT;
	logic [COUNT_W-1:0] cfg_data = '0;

	// selector state as predicted
	logic [HOLD_W-1:0]   hold_ms = '0;
	logic                pressed = 1'b0;
	level_t              level = LVL_NONE;
	logic [TOGGLE_W-1:0] toggle_left = '0;
	logic                lamp = 1'b0;
	logic [FLASH_W-1:0]  blinks = '0;
	logic [SW-1:0]       band = SW'(1);
	logic [SW-1:0]       chan = SW'(1);
	logic [SW-1:0]       pwr = '0;
	logic [COUNT_W-1:0]  band_cnt = COUNT_W'(5);
	logic [COUNT_W-1:0]  chan_cnt = COUNT_W'(8);
	logic [COUNT_W-1:0]  pwr_cnt = COUNT_W'(4);
	logic                dev_ready = 1'b1;

	tick_result_t expected_ticks[$];
	int faults = 0;
	int mismatches = 0;
	int ticks_sent = 0;
	bit calm = 1'b0;
	bit hold_off_go = 1'b0;
	bit hold_off_done = 1'b0;
	int hold_left = 0;

	hold_row_t script [0:25] = '{
		'{ROW_TICKS, REG_BAND_COUNT, 4'd0, 1'b0, 3, 1'b1, ACT_NONE, 4'd1, 4'd1, 4'd0},
		// 26 ticks held is 25 ms elapsed: still a short press
		'{ROW_TICKS, REG_BAND_COUNT, 4'd0, 1'b1, 26, 1'b0, ACT_NONE, 4'd0, 4'd0, 4'd0},
		'{ROW_TICKS, REG_BAND_COUNT, 4'd0, 1'b0, 1, 1'b1, ACT_NONE, 4'd1, 4'd1, 4'd0},
		'{ROW_TICKS, REG_BAND_COUNT, 4'd0, 1'b1, 27, 1'b0, ACT_NONE, 4'd0, 4'd0, 4'd0},
		'{ROW_TICKS, REG_BAND_COUNT, 4'd0, 1'b0, 1, 1'b1, ACT_CHANNEL, 4'd1, 4'd2, 4'd0},
		'{ROW_TICKS, REG_BAND_COUNT, 4'd0, 1'b1, 1002, 1'b0, ACT_NONE, 4'd0, 4'd0, 4'd0},
		'{ROW_TICKS, REG_BAND_COUNT, 4'd0, 1'b0, 1, 1'b1, ACT_BAND, 4'd2, 4'd2, 4'd0},
		'{ROW_TICKS, REG_BAND_COUNT, 4'd0, 1'b1, 3002, 1'b0, ACT_NONE, 4'd0, 4'd0, 4'd0},
		'{ROW_TICKS, REG_BAND_COUNT, 4'd0, 1'b0, 1, 1'b1, ACT_POWER, 4'd2, 4'd2, 4'd1},
		'{ROW_TICKS, REG_BAND_COUNT, 4'd0, 1'b1, 5002, 1'b0, ACT_NONE, 4'd0, 4'd0, 4'd0},
		'{ROW_TICKS, REG_BAND_COUNT, 4'd0, 1'b0, 1, 1'b1, ACT_SAVE, 4'd2, 4'd2, 4'd1},
		// bit 0 clear: device not ready
		'{ROW_WRITE, REG_DEVICE_READY, 4'd2, 1'b0, 0, 1'b0, ACT_NONE, 4'd0, 4'd0, 4'd0},
		'{ROW_TICKS, REG_BAND_COUNT, 4'd0, 1'b1, 30, 1'b0, ACT_NONE, 4'd0, 4'd0, 4'd0},
		'{ROW_TICKS, REG_BAND_COUNT, 4'd0, 1'b0, 1, 1'b1, ACT_NONE, 4'd2, 4'd2, 4'd1},
		// hold timer saturates; save still goes out while not ready
		'{ROW_TICKS, REG_BAND_COUNT, 4'd0, 1'b1, 8300, 1'b0, ACT_NONE, 4'd0, 4'd0, 4'd0},
		'{ROW_TICKS, REG_BAND_COUNT, 4'd0, 1'b0, 1, 1'b1, ACT_SAVE, 4'd2, 4'd2, 4'd1},
		'{ROW_WRITE, REG_DEVICE_READY, 4'd15, 1'b0, 0, 1'b0, ACT_NONE, 4'd0, 4'd0, 4'd0},
		// zero counts
		'{ROW_WRITE, REG_CHANNEL_COUNT, 4'd0, 1'b0, 0, 1'b0, ACT_NONE, 4'd0, 4'd0, 4'd0},
		'{ROW_TICKS, REG_BAND_COUNT, 4'd0, 1'b1, 40, 1'b0, ACT_NONE, 4'd0, 4'd0, 4'd0},
		'{ROW_TICKS, REG_BAND_COUNT, 4'd0, 1'b0, 1, 1'b1, ACT_CHANNEL, 4'd2, 4'd1, 4'd1},
		'{ROW_WRITE, REG_POWER_COUNT, 4'd0, 1'b0, 0, 1'b0, ACT_NONE, 4'd0, 4'd0, 4'd0},
		'{ROW_TICKS, REG_BAND_COUNT, 4'd0, 1'b1, 3100, 1'b0, ACT_NONE, 4'd0, 4'd0, 4'd0},
		'{ROW_TICKS, REG_BAND_COUNT, 4'd0, 1'b0, 1, 1'b1, ACT_POWER, 4'd2, 4'd1, 4'd0},
		'{ROW_WRITE, REG_BAND_COUNT, 4'd0, 1'b0, 0, 1'b0, ACT_NONE, 4'd0, 4'd0, 4'd0},
		'{ROW_TICKS, REG_BAND_COUNT, 4'd0, 1'b1, 1500, 1'b0, ACT_NONE, 4'd0, 4'd0, 4'd0},
		'{ROW_TICKS, REG_BAND_COUNT, 4'd0, 1'b0, 1, 1'b1, ACT_BAND, 4'd1, 4'd1, 4'd0}
	};

	long_press_action_selector_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.button_down (button_down),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.led_lit     (led_lit),
		.action_done (action_done),
		.band_now    (band_now),
		.channel_now (channel_now),
		.power_now   (power_now),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [SW-1:0] step_wrap(input logic [SW-1:0] v,
			input logic [COUNT_W-1:0] cnt);
		return (int'(v) + 1 > int'(cnt)) ? SW'(1) : v + 1'b1;
	endfunction

	function automatic logic [SW-1:0] fit_range(input logic [SW-1:0] v,
			input logic [COUNT_W-1:0] cnt);
		if (int'(v) > int'(cnt))
			return SW'(1);
		if (v == '0)
			return SW'(cnt);
		return v;
	endfunction

	// advances the predicted selector by one millisecond tick
	function automatic tick_result_t advance_selector(input logic down);
		tick_result_t r;
		int used;
		r.act = ACT_NONE;
		if (down) begin
			if (!pressed) begin
				pressed = 1'b1;
				hold_ms = '0;
				level = LVL_NONE;
				toggle_left = TOGGLE_W'(1);
				lamp = 1'b0;
				blinks = '0;
			end else begin
				if (hold_ms < HOLD_SAT)
					hold_ms = hold_ms + 1'b1;
				if (toggle_left != 0)
					toggle_left = toggle_left - 1'b1;
			end
			if (hold_ms > LVL1_MS)
				level = LVL_SAVE;
			else if (hold_ms > LVL2_MS)
				level = LVL_POWER;
			else if (hold_ms > LVL3_MS)
				level = LVL_BAND;
			else if (hold_ms > LVL4_MS)
				level = LVL_CHANNEL;
			if (level != LVL_NONE && toggle_left == 0) begin
				lamp = ~lamp;
				toggle_left = TOGGLE_W'(PHASE_MS + 1);
				if (!lamp)
					blinks = blinks + 1'b1;
				// last blink of the cycle: pad out the rest of the second
				if (int'(blinks) == int'(level)) begin
					used = int'(blinks) * PHASE_MS * 2;
					if (used < PERIOD_MS)
						toggle_left = toggle_left + TOGGLE_W'(PERIOD_MS - used);
					blinks = '0;
				end
			end
		end else if (pressed) begin
			pressed = 1'b0;
			if (level != LVL_NONE) begin
				lamp = 1'b0;
				case (level)
					LVL_CHANNEL: if (dev_ready) begin
						chan = step_wrap(chan, chan_cnt);
						band = fit_range(band, band_cnt);
						r.act = ACT_CHANNEL;
					end
					LVL_BAND: if (dev_ready) begin
						band = step_wrap(band, band_cnt);
						chan = fit_range(chan, chan_cnt);
						r.act = ACT_BAND;
					end
					LVL_POWER: if (dev_ready) begin
						pwr = (int'(pwr) + 1 >= int'(pwr_cnt)) ? '0 : pwr + 1'b1;
						r.act = ACT_POWER;
					end
					LVL_SAVE: r.act = ACT_SAVE;
					default: ;
				endcase
			end
			level = LVL_NONE;
		end
		r.lamp = lamp;
		r.band = band;
		r.chan = chan;
		r.pwr = pwr;
		return r;
	endfunction

	task automatic push_tick(input logic down);
		while (!calm && $urandom_range(99) < 20) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		button_down <= down;
		do @(posedge clk); while (in_stall);
		expected_ticks.push_back(advance_selector(down));
		ticks_sent++;
	endtask

	// stop offering and wait for every pending result
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_ticks.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [COUNT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_BAND_COUNT:    band_cnt = val;
			REG_CHANNEL_COUNT: chan_cnt = val;
			REG_POWER_COUNT:   pwr_cnt = val;
			REG_DEVICE_READY:  dev_ready = val[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// result side: check accepted results, random stalls, one long hold-off
	always @(posedge clk) begin
		tick_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_ticks.size() == 0) begin
				faults++;
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result at %0t", $realtime);
			end else begin
				want = expected_ticks.pop_front();
				if (led_lit !== want.lamp || action_done !== want.act ||
						band_now !== want.band || channel_now !== want.chan ||
						power_now !== want.pwr) begin
					faults++;
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch at %0t (exp/act): led %0d/%0d action %0d/%0d %s",
							$realtime, want.lamp, led_lit, want.act, action_done,
							$sformatf("band %0d/%0d channel %0d/%0d power %0d/%0d",
								want.band, band_now, want.chan, channel_now,
								want.pwr, power_now));
				end
			end
		end
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_off_go && !hold_off_done) begin
			hold_off_done <= 1'b1;
			hold_left <= HOLD_OFF_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < 20);
		end
	end

	initial begin
		hold_row_t row;
		tick_result_t pin;
		int len;
		int sel;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[r]) begin
			row = script[r];
			if (row.kind == ROW_WRITE) begin
				settle();
				write_reg(row.idx, row.val);
			end else begin
				repeat (row.reps) push_tick(row.down);
				if (row.pinned) begin
					pin = expected_ticks.pop_back();
					pin.act = row.act;
					pin.band = row.band;
					pin.chan = row.chan;
					pin.pwr = row.pwr;
					expected_ticks.push_back(pin);
				end
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			settle();
			calm <= (p == 1);
			case (p)
				0: begin
					write_reg(REG_BAND_COUNT, 4'd15);
					write_reg(REG_CHANNEL_COUNT, 4'd15);
					write_reg(REG_POWER_COUNT, 4'd15);
					write_reg(REG_DEVICE_READY, 4'd1);
				end
				1: begin
					write_reg(REG_BAND_COUNT, 4'd1);
					write_reg(REG_CHANNEL_COUNT, 4'd1);
					write_reg(REG_POWER_COUNT, 4'd1);
					write_reg(REG_DEVICE_READY, 4'd1);
				end
				default: begin
					write_reg(REG_BAND_COUNT, 4'($urandom_range(15)));
					write_reg(REG_CHANNEL_COUNT, 4'($urandom_range(15)));
					write_reg(REG_POWER_COUNT, 4'($urandom_range(15)));
					write_reg(REG_DEVICE_READY, 4'($urandom_range(15)));
				end
			endcase
			for (int k = 0; k < PRESSES_PER_PHASE && ticks_sent < TICK_CAP; k++) begin
				if (p == 0 && k == 4)
					hold_off_go <= 1'b1;
				if ($urandom_range(9) == 0) begin
					// noise burst
					repeat (30) push_tick(1'($urandom_range(1)));
				end else begin
					sel = $urandom_range(99);
					if (sel < 45)
						len = $urandom_range(1, 60);
					else if (sel < 75)
						len = $urandom_range(61, 1000);
					else if (sel < 88)
						len = $urandom_range(990, 1100);
					else if (sel < 96)
						len = $urandom_range(2990, 3100);
					else
						len = $urandom_range(4990, 5100);
					repeat (len) push_tick(1'b1);
					repeat ($urandom_range(1, 12)) push_tick(1'b0);
				end
			end
		end

		settle();
		repeat (10) @(posedge clk);
		if (expected_ticks.size() != 0)
			faults++;
		if (faults == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Regression FAIL");
		$finish;
	end
endmodule

[filelist.f]
+incdir+design
design/lpas_pkg.sv
design/lpas_hold.sv
design/lpas_settings.sv
design/long_press_action_selector_unit.sv
tb/long_press_action_selector_unit_tb.sv
